// ===== hw/rtl/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// grc_pkg - shared types and constants of the gyro rate offset calibrator
// fixed field widths, conversion constants, sequencer states, result layout
// ----------------------------------------------------------------------------
package grc_pkg;

   // input field layout
   localparam int unsigned WORD_W     = 16;
   localparam int unsigned REJECT_BIT = 15;
   localparam int unsigned CODE_LSB   = 1;
   localparam int unsigned CODE_W     = 11;

   // conversion: code * FULL_SCALE / 2**SCALE_SHIFT - FULL_SCALE
   localparam int unsigned FULL_SCALE  = 300;
   localparam int unsigned SCALE_W     = 9;
   localparam int unsigned SCALE_SHIFT = 10;
   localparam int unsigned PROD_W      = CODE_W + SCALE_W;

   // rate and offset widths
   localparam int unsigned RATE_W = 11;
   localparam int unsigned VAL_W  = 10;

   // action codes carried on tuser
   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_START  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONV,
      ST_READ,
      ST_CMP,
      ST_APPEND,
      ST_COUNT,
      ST_SUM_RD,
      ST_SUM_MUL,
      ST_SUM_ACC,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   // result transfer, lowest bits last
   typedef struct packed {
      logic signed [VAL_W-1:0]  offset;
      logic                     calibration_failed;
      logic                     calibrating;
      logic                     sample_accepted;
      logic signed [RATE_W-1:0] rate;
   } rsp_type;

endpackage

// ===== hw/rtl/grc_ram.sv =====
// ----------------------------------------------------------------------------
// grc_ram - generic single write, single read ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module grc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/grc_div.sv =====
// ----------------------------------------------------------------------------
// grc_div - unsigned divider by a constant
// multiplication by the rounded-up reciprocal; done marks the valid quotient
// ----------------------------------------------------------------------------
module grc_div #(
   parameter int unsigned WIDTH   = 18,
   parameter int unsigned DIVISOR = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   // quotient = (dividend * RECIP) >> SHIFT, exact for every WIDTH-bit dividend
   localparam int unsigned     SHIFT   = WIDTH + $clog2(DIVISOR);
   localparam int unsigned     RECIP_W = WIDTH + 1;
   localparam int unsigned     PROD_W  = WIDTH + RECIP_W;
   localparam longint unsigned RECIP   =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

   logic [WIDTH-1:0]  num_ff, num_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      num_in  = start ? dividend : num_ff;
      prod_in = PROD_W'(num_ff) * PROD_W'(RECIP_V);
      busy_in = start;
      done_in = busy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      prod_ff <= prod_in;
   end

   assign done     = done_ff;
   assign quotient = WIDTH'(prod_ff >> SHIFT);

endmodule

// ===== hw/rtl/gyro_rate_offset_calibrator_top.sv =====
// ----------------------------------------------------------------------------
// gyro_rate_offset_calibrator_top - gyro zero-rate offset calibrator
// converts gyro samples to deg/s and learns the standing-still offset
// ----------------------------------------------------------------------------
// Each request transfer is either a gyro sample (tuser = 0) or a start command
// (tuser = 1); every request yields exactly one response transfer. A sample
// whose status bit 15 is set is rejected; otherwise the 11-bit code in data
// bits 11..1 becomes code*300/1024 - 300 deg/s minus the stored offset. A start
// command clears the offset and the value table and gathers CAL_SAMPLES
// samples; each rate goes into a table of TABLE_ENTRIES distinct values with
// counts (new values are dropped once it is full), and after the last sample
// the offset is sum(value*count)/CAL_SAMPLES, truncated toward zero. A rejected
// sample during calibration aborts it and raises calibration_failed.
// Sequence: a start command or a rejected sample goes from taking the request
// straight to loading the response, a plain sample first passes through the
// conversion state, and loading the response waits while the previous response
// still waits for its transfer. A calibration sample walks the table entries,
// a read and then a compare for each on the single table ram read port, and
// appends the value when it is new. The final sample of a calibration then
// reads, multiplies and accumulates each table entry for the weighted sum and
// divides by CAL_SAMPLES, done as a multiplication by its reciprocal. The
// table lives in a small ram whose fill count marks the valid entries, so no
// clearing pass is needed after reset or start. A new request is taken while
// the previous response still waits in the output register.
// ----------------------------------------------------------------------------
module gyro_rate_offset_calibrator_top #(
   parameter int unsigned TABLE_ENTRIES = 8,
   parameter int unsigned CAL_SAMPLES   = 20
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] status_word, [31:16] data_word
   input  logic [0:0]  req_tuser,   // [0] action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [10:0] rate, [11] sample_accepted,
                                    // [12] calibrating, [13] calibration_failed,
                                    // [23:14] offset
);

   // table geometry
   localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned USED_W = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned CNT_W  = $clog2(CAL_SAMPLES + 1);
   localparam int unsigned WORD_W = grc_pkg::VAL_W + CNT_W;
   // weighted sum bound: |value| < 2**(VAL_W-1), total count <= CAL_SAMPLES
   localparam int unsigned SUM_W  = grc_pkg::VAL_W + CNT_W + 1;

   // sequencer and control state
   grc_pkg::state_type state_ff, state_in;
   logic                               active_ff, active_in;
   logic                               failed_ff, failed_in;
   logic                               accepted_ff, accepted_in;
   logic [USED_W-1:0]                  used_ff, used_in;
   logic [CNT_W-1:0]                   samples_ff, samples_in;
   logic signed [grc_pkg::VAL_W-1:0]   offset_ff, offset_in;
   logic signed [grc_pkg::RATE_W-1:0]  last_rate_ff, last_rate_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [grc_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic signed [SUM_W-1:0]     term_ff, term_in;
   logic signed [SUM_W-1:0]     acc_ff, acc_in;
   logic                        neg_ff, neg_in;
   grc_pkg::rsp_type            rsp_ff, rsp_in;

   // table ram port
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [WORD_W-1:0]           wr_data;
   logic [IDX_W-1:0]            rd_addr;
   logic [WORD_W-1:0]           rd_data;

   // divider port
   logic                        div_start;
   logic [SUM_W-1:0]            div_dividend;
   logic                        div_done;
   logic [SUM_W-1:0]            div_quotient;

   // decoded fields and helpers
   logic                                req_fire;
   logic [grc_pkg::CODE_W-1:0]          code;
   logic signed [grc_pkg::RATE_W:0]     rate_calc;
   logic signed [grc_pkg::VAL_W-1:0]    rd_val;
   logic [CNT_W-1:0]                    rd_cnt;
   logic [USED_W-1:0]                   idx_next;
   logic [CNT_W-1:0]                    samples_next;
   logic signed [grc_pkg::VAL_W-1:0]    quot_val;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == grc_pkg::ST_IDLE);
   assign code       = req_tdata[grc_pkg::WORD_W + grc_pkg::CODE_LSB +: grc_pkg::CODE_W];

   // table word: value in the upper bits, count in the lower bits
   assign rd_val = rd_data[WORD_W-1 -: grc_pkg::VAL_W];
   assign rd_cnt = rd_data[CNT_W-1:0];

   // deg = code*300 >> 10 - 300, then minus offset; fits 11 bits signed
   assign rate_calc = $signed({2'b00, prod_ff[grc_pkg::PROD_W-1 -: grc_pkg::VAL_W]})
                      - $signed((grc_pkg::RATE_W + 1)'(grc_pkg::FULL_SCALE))
                      - (grc_pkg::RATE_W + 1)'(offset_ff);

   assign idx_next     = USED_W'(idx_ff) + 1'b1;
   assign samples_next = samples_ff + 1'b1;
   assign quot_val     = div_quotient[grc_pkg::VAL_W-1:0];
   // magnitude of the sum, sign taken straight from the accumulator
   assign div_dividend = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);

   grc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   grc_div #(
      .WIDTH   (SUM_W),
      .DIVISOR (CAL_SAMPLES)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      failed_in    = failed_ff;
      accepted_in  = accepted_ff;
      used_in      = used_ff;
      samples_in   = samples_ff;
      offset_in    = offset_ff;
      last_rate_in = last_rate_ff;
      rsp_valid_in = rsp_valid_ff;
      prod_in      = prod_ff;
      idx_in       = idx_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = {last_rate_ff[grc_pkg::VAL_W-1:0], CNT_W'(1)};
      rd_addr      = idx_ff;
      div_start    = 1'b0;

      // response register frees on its transfer
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         grc_pkg::ST_IDLE: begin
            if (req_fire) begin
               accepted_in = 1'b0;
               prod_in     = grc_pkg::PROD_W'(code) * grc_pkg::PROD_W'(grc_pkg::FULL_SCALE);
               if (req_tuser[0] == grc_pkg::ACTION_START) begin
                  // start: clear offset and table, begin gathering
                  offset_in  = '0;
                  used_in    = '0;
                  samples_in = '0;
                  active_in  = 1'b1;
                  failed_in  = 1'b0;
                  state_in   = grc_pkg::ST_DONE;
               end else if (req_tdata[grc_pkg::REJECT_BIT]) begin
                  // rejected sample aborts a running calibration
                  if (active_ff) begin
                     active_in = 1'b0;
                     failed_in = 1'b1;
                  end
                  state_in = grc_pkg::ST_DONE;
               end else begin
                  accepted_in = 1'b1;
                  state_in    = grc_pkg::ST_CONV;
               end
            end
         end
         grc_pkg::ST_CONV: begin
            last_rate_in = rate_calc[grc_pkg::RATE_W-1:0];
            idx_in       = '0;
            if (!active_ff) begin
               state_in = grc_pkg::ST_DONE;
            end else if (used_ff == '0) begin
               state_in = grc_pkg::ST_APPEND;
            end else begin
               state_in = grc_pkg::ST_READ;
            end
         end
         grc_pkg::ST_READ: begin
            // read issued at idx, data valid next cycle
            state_in = grc_pkg::ST_CMP;
         end
         grc_pkg::ST_CMP: begin
            if (rd_val == last_rate_ff[grc_pkg::VAL_W-1:0]) begin
               wr_en    = 1'b1;
               wr_data  = {rd_val, rd_cnt + 1'b1};
               state_in = grc_pkg::ST_COUNT;
            end else if (idx_next == used_ff) begin
               state_in = grc_pkg::ST_APPEND;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = grc_pkg::ST_READ;
            end
         end
         grc_pkg::ST_APPEND: begin
            // new distinct value, dropped when the table is full
            if (used_ff != USED_W'(TABLE_ENTRIES)) begin
               wr_en   = 1'b1;
               wr_addr = used_ff[IDX_W-1:0];
               used_in = used_ff + 1'b1;
            end
            state_in = grc_pkg::ST_COUNT;
         end
         grc_pkg::ST_COUNT: begin
            samples_in = samples_next;
            idx_in     = '0;
            acc_in     = '0;
            if (samples_next == CNT_W'(CAL_SAMPLES)) begin
               state_in = grc_pkg::ST_SUM_RD;
            end else begin
               state_in = grc_pkg::ST_DONE;
            end
         end
         grc_pkg::ST_SUM_RD: begin
            state_in = grc_pkg::ST_SUM_MUL;
         end
         grc_pkg::ST_SUM_MUL: begin
            term_in  = SUM_W'(rd_val) * $signed(SUM_W'(rd_cnt));
            state_in = grc_pkg::ST_SUM_ACC;
         end
         grc_pkg::ST_SUM_ACC: begin
            acc_in = acc_ff + term_ff;
            if (idx_next == used_ff) begin
               state_in = grc_pkg::ST_DIV_GO;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = grc_pkg::ST_SUM_RD;
            end
         end
         grc_pkg::ST_DIV_GO: begin
            neg_in   = acc_ff[SUM_W-1];
            state_in = grc_pkg::ST_DIV_WAIT;
         end
         grc_pkg::ST_DIV_WAIT: begin
            // wait for the divider's done, which marks the quotient of the magnitude
            if (div_done) begin
               offset_in = neg_ff ? -quot_val : quot_val;
               active_in = 1'b0;
               state_in  = grc_pkg::ST_DONE;
            end
         end
         grc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in           = 1'b1;
               rsp_in.rate            = last_rate_ff;
               rsp_in.sample_accepted = accepted_ff;
               rsp_in.calibrating     = active_ff;
               rsp_in.calibration_failed = failed_ff;
               rsp_in.offset          = offset_ff;
               state_in               = grc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = grc_pkg::ST_IDLE;
         end
      endcase

      // divider launch with the magnitude of the finished sum
      if (state_ff == grc_pkg::ST_DIV_GO) begin
         div_start = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grc_pkg::ST_IDLE;
         active_ff    <= 1'b0;
         failed_ff    <= 1'b0;
         accepted_ff  <= 1'b0;
         used_ff      <= '0;
         samples_ff   <= '0;
         offset_ff    <= '0;
         last_rate_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         failed_ff    <= failed_in;
         accepted_ff  <= accepted_in;
         used_ff      <= used_in;
         samples_ff   <= samples_in;
         offset_ff    <= offset_in;
         last_rate_ff <= last_rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff <= prod_in;
      idx_ff  <= idx_in;
      term_ff <= term_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

// ===== verif/gyro_rate_offset_calibrator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gyro_rate_offset_calibrator_top_tb - testbench of the gyro offset calibrator
// drives sample and start transfers, predicts every response transfer with an
// independent calibration model and compares it field by field
// ----------------------------------------------------------------------------
module gyro_rate_offset_calibrator_top_tb;

   localparam int TABLE_ENTRIES   = 8;
   localparam int CAL_SAMPLES     = 20;
   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 7;
   localparam int ITEMS_PER_PHASE = 170;
   localparam int HOLD_CYCLES     = 300;
   // leave margin after the last sample for its response
   localparam int DRAIN_CYCLES    = 100;
   // bound for ~750 transfers plus the long hold
   localparam int CYCLE_LIMIT     = 400000;

   // predicts the calibrator and keeps the responses still owed by the block
   class calib_scoreboard;
      int               offset_val;
      int               last_rate;
      int               table_val[TABLE_ENTRIES];
      int               table_cnt[TABLE_ENTRIES];
      int               used;
      int               taken;
      bit               active;
      bit               failed;
      int               errors;
      grc_pkg::rsp_type expected_rsp[$];

      function new();
         offset_val = 0;
         last_rate  = 0;
         used       = 0;
         taken      = 0;
         active     = 1'b0;
         failed     = 1'b0;
         errors     = 0;
      endfunction

      // fold one accepted request into the model and queue its response
      function void note_request(logic action, logic [15:0] status, logic [15:0] data);
         int               code;
         int               deg;
         int               total;
         bit               accepted;
         bit               found;
         grc_pkg::rsp_type exp_rsp;
         accepted = 1'b0;
         if (action == grc_pkg::ACTION_START) begin
            offset_val = 0;
            used       = 0;
            taken      = 0;
            active     = 1'b1;
            failed     = 1'b0;
         end else if (status[grc_pkg::REJECT_BIT]) begin
            if (active) begin
               active = 1'b0;
               failed = 1'b1;
            end
         end else begin
            code      = int'(data[grc_pkg::CODE_LSB +: grc_pkg::CODE_W]);
            deg       = code * int'(grc_pkg::FULL_SCALE) / (1 << grc_pkg::SCALE_SHIFT)
                        - int'(grc_pkg::FULL_SCALE);
            last_rate = deg - offset_val;
            accepted  = 1'b1;
            if (active) begin
               found = 1'b0;
               for (int k = 0; k < used; k++) begin
                  if (!found && table_val[k] == last_rate) begin
                     table_cnt[k]++;
                     found = 1'b1;
                  end
               end
               // a new value is dropped once the table is full
               if (!found && used < TABLE_ENTRIES) begin
                  table_val[used] = last_rate;
                  table_cnt[used] = 1;
                  used++;
               end
               taken++;
               if (taken >= CAL_SAMPLES) begin
                  total = 0;
                  for (int k = 0; k < used; k++) total += table_val[k] * table_cnt[k];
                  offset_val = total / CAL_SAMPLES;
                  active     = 1'b0;
               end
            end
         end
         exp_rsp.rate               = last_rate[grc_pkg::RATE_W-1:0];
         exp_rsp.sample_accepted    = accepted;
         exp_rsp.calibrating        = active;
         exp_rsp.calibration_failed = failed;
         exp_rsp.offset             = offset_val[grc_pkg::VAL_W-1:0];
         expected_rsp.push_back(exp_rsp);
      endfunction

      function void check_response(logic [23:0] raw);
         grc_pkg::rsp_type got;
         grc_pkg::rsp_type exp_rsp;
         got = grc_pkg::rsp_type'(raw);
         if (expected_rsp.size() == 0) begin
            $error("response transfer with nothing expected: %h", raw);
            errors++;
            return;
         end
         exp_rsp = expected_rsp.pop_front();
         if (got.rate !== exp_rsp.rate) begin
            $error("rate: expected %0d, got %0d", exp_rsp.rate, got.rate);
            errors++;
         end
         if (got.sample_accepted !== exp_rsp.sample_accepted) begin
            $error("sample_accepted: expected %0d, got %0d",
                   exp_rsp.sample_accepted, got.sample_accepted);
            errors++;
         end
         if (got.calibrating !== exp_rsp.calibrating) begin
            $error("calibrating: expected %0d, got %0d",
                   exp_rsp.calibrating, got.calibrating);
            errors++;
         end
         if (got.calibration_failed !== exp_rsp.calibration_failed) begin
            $error("calibration_failed: expected %0d, got %0d",
                   exp_rsp.calibration_failed, got.calibration_failed);
            errors++;
         end
         if (got.offset !== exp_rsp.offset) begin
            $error("offset: expected %0d, got %0d", exp_rsp.offset, got.offset);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [15:0] status_word, [31:16] data_word
   logic [0:0]  req_tuser;   // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [10:0] rate, [11] sample_accepted, [12] calibrating,
                             // [13] calibration_failed, [23:14] offset

   calib_scoreboard sb;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int items_sent     = 0;
   int cycles         = 0;

   gyro_rate_offset_calibrator_top #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .CAL_SAMPLES   (CAL_SAMPLES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // one request transfer, with an optional gap in front of it
   task automatic send_req(input logic action, input logic [15:0] status,
                           input logic [15:0] data);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {data, status};
      do @(posedge clock); while (!req_tready);
      sb.note_request(action, status, data);
      items_sent++;
   endtask

   function automatic logic [15:0] status_word(bit reject);
      logic [15:0] s;
      s                      = 16'($urandom);
      s[grc_pkg::REJECT_BIT] = reject;
      return s;
   endfunction

   // adc code in bits 11..1, the unused bits random
   function automatic logic [15:0] data_for_code(int code);
      logic [15:0] d;
      d                                       = 16'($urandom);
      d[grc_pkg::CODE_LSB +: grc_pkg::CODE_W] = grc_pkg::CODE_W'(code);
      return d;
   endfunction

   task automatic run_directed();
      int codes[10] = '{0, 2047, 1024, 1023, 512, 1536, 100, 1900, 700, 1300};
      // start ignores both words
      send_req(grc_pkg::ACTION_START, 16'hFFFF, 16'hFFFF);
      // top code, every status bit but the reject bit, unused data bits set
      send_req(grc_pkg::ACTION_SAMPLE, 16'h7FFF, 16'hFFFF);
      // reject while calibrating aborts and flags failure
      send_req(grc_pkg::ACTION_SAMPLE, 16'h8000, 16'h0000);
      // reject while idle changes nothing
      send_req(grc_pkg::ACTION_SAMPLE, 16'hFFFF, 16'h1234);
      send_req(grc_pkg::ACTION_START, 16'h0000, 16'h0000);
      send_req(grc_pkg::ACTION_SAMPLE, 16'h0000, data_for_code(1024));
      // restart while calibrating
      send_req(grc_pkg::ACTION_START, 16'h0000, 16'h0000);
      // ten distinct rates overflow the table, both code extremes included
      for (int n = 0; n < CAL_SAMPLES; n++)
         send_req(grc_pkg::ACTION_SAMPLE, status_word(1'b0), data_for_code(codes[n % 10]));
      // corrected by the fresh offset
      send_req(grc_pkg::ACTION_SAMPLE, 16'h0000, data_for_code(1024));
   endtask

   // start, full calibration, 1-6 samples; a reject or restart may end it early
   task automatic run_calibration();
      int pool[12];
      int pool_n;
      int kind;
      pool_n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      kind   = $urandom_range(0, 3);
      foreach (pool[i]) begin
         case (kind)
            0: begin
               pool[i] = $urandom_range(0, 2047);
            end
            1: begin
               pool[i] = $urandom_range(1012, 1036);
            end
            2: begin
               pool[i] = $urandom_range(0, 3);
            end
            default: begin
               pool[i] = $urandom_range(2044, 2047);
            end
         endcase
      end
      send_req(grc_pkg::ACTION_START, 16'($urandom), 16'($urandom));
      for (int n = 0; n < CAL_SAMPLES; n++) begin
         if ($urandom_range(0, 99) < 2) begin
            if ($urandom_range(0, 1) == 1)
               send_req(grc_pkg::ACTION_SAMPLE, status_word(1'b1), 16'($urandom));
            else
               send_req(grc_pkg::ACTION_START, 16'($urandom), 16'($urandom));
            return;
         end
         send_req(grc_pkg::ACTION_SAMPLE, status_word(1'b0),
                  data_for_code(pool[$urandom_range(0, pool_n - 1)]));
      end
      repeat ($urandom_range(1, 6))
         send_req(grc_pkg::ACTION_SAMPLE, status_word(1'b0),
                  data_for_code($urandom_range(0, 2047)));
   endtask

   task automatic run_random(int count);
      int goal;
      goal = items_sent + count;
      while (items_sent < goal) begin
         if ($urandom_range(0, 99) < 75)
            run_calibration();
         else
            send_req(grc_pkg::ACTION_SAMPLE, status_word($urandom_range(0, 1)),
                     16'($urandom));
      end
   endtask

   // response side: check each transfer, stall at random or for the long hold
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // run limit
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= grc_pkg::ACTION_SAMPLE;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // no idling, with one long receiver hold so the block backs up
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = HOLD_CYCLES;
      run_random(ITEMS_PER_PHASE);

      send_idle_pct  = 46;
      recv_stall_pct = 0;
      run_random(ITEMS_PER_PHASE);

      send_idle_pct  = 0;
      recv_stall_pct = 46;
      run_random(ITEMS_PER_PHASE);

      send_idle_pct  = 16;
      recv_stall_pct = 16;
      run_random(ITEMS_PER_PHASE);

      req_tvalid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.expected_rsp.size() != 0) begin
         $error("%0d response transfers never arrived", sb.expected_rsp.size());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
